// ===== src/bfm_pkg.sv =====
// ----------------------------------------------------------------------------
// bfm_pkg
// Shared types and constants for the bloom filter with murmur3 hashing.
// ----------------------------------------------------------------------------
package bfm_pkg;

   // longest key handled, in bytes (key field is 64 bits wide)
   localparam logic [3:0] KEY_BYTES = 4'd8;

   // murmur3 x86_32 constants
   localparam logic [31:0] MM_C1 = 32'hcc9e2d51;
   localparam logic [31:0] MM_C2 = 32'h1b873593;
   localparam logic [31:0] MM_N  = 32'he6546b64;
   localparam logic [31:0] MM_F1 = 32'h85ebca6b;
   localparam logic [31:0] MM_F2 = 32'hc2b2ae35;

   // command codes
   localparam logic CMD_TEST = 1'b0;
   localparam logic CMD_ADD  = 1'b1;

   // register reset values
   localparam logic [4:0]  HASH_COUNT_RST    = 5'd3;
   localparam logic [16:0] NUM_BITS_USED_RST = 17'd65536;

   // bit store access command
   typedef struct packed {
      logic rd;
      logic wr;
      logic wdata;
   } bfm_mem_cmd_type;

endpackage

// ===== src/bloom_filter_murmur3.sv =====
// ----------------------------------------------------------------------------
// bloom_filter_murmur3
// Bloom filter over a one-bit store, indexed by murmur3 x86_32 hashes of
// the key for seeds 0 to k-1; one shared multiplier under a sequencer.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  req       in         req_valid/req_stall  req_command, req_key_bytes,
//                                            req_key_length
//  rsp       out        rsp_valid/rsp_stall  rsp_present
//  csr       in/out     psel/penable/pready  paddr, pwrite, pwdata, prdata
//
//  a transaction is sequenced through the single multiplier and the one bit
//  store port, and a test ends early when it hits a clear bit.
//  after reset a clearing pass over all FILTER_BITS addresses runs with req_stall high.
//  a finished result waits in the output register while rsp_stall is high,
//  and a new transaction is accepted meanwhile.
// ----------------------------------------------------------------------------
module bloom_filter_murmur3
   import bfm_pkg::*;
#(
   parameter int FILTER_BITS = 65536,
   parameter int MAX_HASHES  = 16
)
(
   input  logic        clock,
   input  logic        reset,
   // input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [63:0] req_key_bytes,
   input  logic [3:0]  req_key_length,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_present,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int AW = $clog2(FILTER_BITS);

   typedef enum logic {
      CSR_HASH_COUNT = 1'b0,
      CSR_NUM_BITS   = 1'b1
   } csr_sel_type;

   logic [4:0]      hash_count_ff;
   logic [16:0]     num_bits_used_ff;
   csr_sel_type     csr_sel;
   logic [31:0]     mul_a;
   logic [31:0]     mul_b;
   logic [63:0]     product;
   bfm_mem_cmd_type mem_cmd;
   logic [AW-1:0]   mem_addr;
   logic            mem_rdata;

   assign pready  = 1'b1;
   assign csr_sel = csr_sel_type'(paddr[2]);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         hash_count_ff    <= HASH_COUNT_RST;
         num_bits_used_ff <= NUM_BITS_USED_RST;
      end else if (psel && penable && pwrite && pready) begin
         case (csr_sel)
            CSR_HASH_COUNT: hash_count_ff    <= pwdata[4:0];
            CSR_NUM_BITS:   num_bits_used_ff <= pwdata[16:0];
            default: begin
               hash_count_ff <= hash_count_ff;
            end
         endcase
      end
   end

   // configuration reads
   always_comb begin
      case (csr_sel)
         CSR_HASH_COUNT: prdata = {27'h0, hash_count_ff};
         CSR_NUM_BITS:   prdata = {15'h0, num_bits_used_ff};
         default:        prdata = 32'h0;
      endcase
   end

   bfm_ctrl #(
      .FILTER_BITS (FILTER_BITS),
      .MAX_HASHES  (MAX_HASHES)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .hash_count     (hash_count_ff),
      .num_bits_used  (num_bits_used_ff),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_key_bytes  (req_key_bytes),
      .req_key_length (req_key_length),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_present    (rsp_present),
      .mul_a          (mul_a),
      .mul_b          (mul_b),
      .product        (product),
      .mem_cmd        (mem_cmd),
      .mem_addr       (mem_addr),
      .mem_rdata      (mem_rdata)
   );

   bfm_mul u_mul (
      .clock      (clock),
      .mul_a      (mul_a),
      .mul_b      (mul_b),
      .product_ff (product)
   );

   bfm_bit_store #(
      .FILTER_BITS (FILTER_BITS)
   ) u_store (
      .clock    (clock),
      .mem_cmd  (mem_cmd),
      .mem_addr (mem_addr),
      .rdata_ff (mem_rdata)
   );

endmodule

// ===== src/bfm_mul.sv =====
// ----------------------------------------------------------------------------
// bfm_mul
// Shared 32x32 multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module bfm_mul
   import bfm_pkg::*;
(
   input  logic        clock,
   input  logic [31:0] mul_a,
   input  logic [31:0] mul_b,
   output logic [63:0] product_ff
);

   // one multiply per cycle, registered product
   always_ff @(posedge clock) begin
      product_ff <= 64'(mul_a) * 64'(mul_b);
   end

endmodule

// ===== src/bfm_bit_store.sv =====
// ----------------------------------------------------------------------------
// bfm_bit_store
// Single-bit filter memory, one access a cycle, registered read data.
// ----------------------------------------------------------------------------
module bfm_bit_store
   import bfm_pkg::*;
#(
   parameter int FILTER_BITS = 65536
)
(
   input  logic                           clock,
   input  bfm_mem_cmd_type                mem_cmd,
   input  logic [$clog2(FILTER_BITS)-1:0] mem_addr,
   output logic                           rdata_ff
);

   logic mem [FILTER_BITS];

   // write port
   always_ff @(posedge clock) begin
      if (mem_cmd.wr) begin
         mem[mem_addr] <= mem_cmd.wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (mem_cmd.rd) begin
         rdata_ff <= mem[mem_addr];
      end
   end

endmodule

// ===== src/bfm_ctrl.sv =====
// ----------------------------------------------------------------------------
// bfm_ctrl
// Sequencer: clears the store, mixes key blocks, runs the per-seed hash
// through the shared multiplier, tests and sets filter bits, holds result.
// ----------------------------------------------------------------------------
module bfm_ctrl
   import bfm_pkg::*;
#(
   parameter int FILTER_BITS = 65536,
   parameter int MAX_HASHES  = 16
)
(
   input  logic                           clock,
   input  logic                           reset,
   // configuration
   input  logic [4:0]                     hash_count,
   input  logic [16:0]                    num_bits_used,
   // input channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_command,
   input  logic [63:0]                    req_key_bytes,
   input  logic [3:0]                     req_key_length,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_present,
   // shared multiplier
   output logic [31:0]                    mul_a,
   output logic [31:0]                    mul_b,
   input  logic [63:0]                    product,
   // bit store
   output bfm_mem_cmd_type                mem_cmd,
   output logic [$clog2(FILTER_BITS)-1:0] mem_addr,
   input  logic                           mem_rdata
);

   localparam int AW = $clog2(FILTER_BITS);
   localparam int SW = $clog2(MAX_HASHES + 1);
   localparam logic [AW-1:0] LAST_ADDR = AW'(FILTER_BITS - 1);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MIX_A,
      ST_MIX_B,
      ST_MIX_C,
      ST_SEED,
      ST_HBLK,
      ST_FIN2,
      ST_IDX,
      ST_RD,
      ST_CHK,
      ST_DONE
   } state_type;

   state_type        state_ff;
   logic [AW-1:0]    clr_ff;
   logic             cmd_ff;
   logic [63:0]      key_ff;
   logic [3:0]       len_ff;
   logic [SW-1:0]    k_ff;
   logic [SW-1:0]    seed_ff;
   logic [16:0]      used_ff;
   logic             j_ff;
   logic [1:0]       blk_ff;
   logic [31:0]      mix_ff [2];
   logic [31:0]      h_ff;
   logic [AW-1:0]    idx_ff;
   logic             present_ff;
   logic             rsp_valid_ff;
   logic             rsp_present_ff;

   logic             req_accept;
   logic [3:0]       len_in;
   logic [63:0]      key_in;
   logic [SW-1:0]    k_in;
   logic [16:0]      used_in;
   logic [1:0]       nblk;
   logic             rem_nz;
   logic [1:0]       nmix;
   logic [1:0]       nmix_in;
   logic [31:0]      round_h;
   logic [31:0]      fin1_x;
   logic [31:0]      fin2_y;
   logic [31:0]      fin3_z;
   logic [AW-1:0]    prod_idx;
   logic             last_seed;

   function automatic logic [31:0] rotl15(input logic [31:0] x);
      rotl15 = {x[16:0], x[31:17]};
   endfunction

   function automatic logic [31:0] rotl13(input logic [31:0] x);
      rotl13 = {x[18:0], x[31:19]};
   endfunction

   assign req_accept  = req_valid && !req_stall;
   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_present = rsp_present_ff;

   // saturate length, hash count and bits in use, mask unused key bytes
   always_comb begin
      len_in = (req_key_length > KEY_BYTES) ? KEY_BYTES : req_key_length;
      for (int b = 0; b < 8; b++) begin
         key_in[8*b +: 8] = (4'(b) < len_in) ? req_key_bytes[8*b +: 8] : 8'h00;
      end
      k_in = ({2'b00, hash_count} > 7'(MAX_HASHES)) ? SW'(MAX_HASHES)
                                                    : SW'(hash_count);
      used_in = ({8'h00, num_bits_used} > 25'(FILTER_BITS)) ? 17'(FILTER_BITS)
                                                           : num_bits_used;
      nmix_in = len_in[3:2] + 2'(len_in[1:0] != 2'b00);
   end

   // block and tail counts of the held key
   assign nblk   = len_ff[3:2];
   assign rem_nz = (len_ff[1:0] != 2'b00);
   assign nmix   = nblk + 2'(rem_nz);

   // hash body round, finalization steps and index
   always_comb begin
      round_h = rotl13(h_ff ^ mix_ff[blk_ff[0]]);
      round_h = (round_h << 2) + round_h + MM_N;
      fin1_x  = h_ff ^ (rem_nz ? mix_ff[nblk[0]] : 32'h0) ^ {28'h0, len_ff};
      fin1_x  = fin1_x ^ (fin1_x >> 16);
      fin2_y  = product[31:0] ^ (product[31:0] >> 13);
      fin3_z  = product[31:0] ^ (product[31:0] >> 16);
      prod_idx = product[32 +: AW];
   end

   assign last_seed = ((seed_ff + SW'(1)) == k_ff);

   // multiplier operand select
   always_comb begin
      mul_a = 32'h0;
      mul_b = 32'h0;
      case (state_ff)
         ST_MIX_A: begin
            mul_a = j_ff ? key_ff[63:32] : key_ff[31:0];
            mul_b = MM_C1;
         end
         ST_MIX_B: begin
            mul_a = rotl15(product[31:0]);
            mul_b = MM_C2;
         end
         ST_HBLK: begin
            mul_a = fin1_x;
            mul_b = MM_F1;
         end
         ST_FIN2: begin
            mul_a = fin2_y;
            mul_b = MM_F2;
         end
         ST_IDX: begin
            mul_a = {15'h0, used_ff};
            mul_b = fin3_z;
         end
         default: begin
            mul_a = 32'h0;
            mul_b = 32'h0;
         end
      endcase
   end

   // bit store access select
   always_comb begin
      mem_cmd  = '0;
      mem_addr = idx_ff;
      case (state_ff)
         ST_CLEAR: begin
            mem_cmd.wr = 1'b1;
            mem_addr   = clr_ff;
         end
         ST_RD: begin
            mem_cmd.rd = 1'b1;
            mem_addr   = prod_idx;
         end
         ST_CHK: begin
            mem_cmd.wr    = (cmd_ff == CMD_ADD) && !mem_rdata;
            mem_cmd.wdata = 1'b1;
            mem_addr      = idx_ff;
         end
         default: begin
            mem_cmd  = '0;
            mem_addr = idx_ff;
         end
      endcase
   end

   // sequencer state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drop an accepted result unless a new one is loaded this cycle
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            // clearing pass over the bit store
            ST_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (clr_ff == LAST_ADDR) begin
                  state_ff <= ST_IDLE;
               end
            end
            // capture a transaction
            ST_IDLE: begin
               if (req_accept) begin
                  cmd_ff     <= req_command;
                  key_ff     <= key_in;
                  len_ff     <= len_in;
                  k_ff       <= k_in;
                  used_ff    <= used_in;
                  seed_ff    <= '0;
                  j_ff       <= 1'b0;
                  present_ff <= 1'b1;
                  if (k_in == '0) begin
                     state_ff <= ST_DONE;
                  end else if (nmix_in != 2'd0) begin
                     state_ff <= ST_MIX_A;
                  end else begin
                     state_ff <= ST_SEED;
                  end
               end
            end
            // seed-independent block mixing
            ST_MIX_A: begin
               state_ff <= ST_MIX_B;
            end
            ST_MIX_B: begin
               state_ff <= ST_MIX_C;
            end
            ST_MIX_C: begin
               mix_ff[j_ff] <= product[31:0];
               if (!j_ff && (nmix == 2'd2)) begin
                  j_ff     <= 1'b1;
                  state_ff <= ST_MIX_A;
               end else begin
                  state_ff <= ST_SEED;
               end
            end
            // start one seed
            ST_SEED: begin
               h_ff     <= 32'(seed_ff);
               blk_ff   <= 2'd0;
               state_ff <= ST_HBLK;
            end
            // body rounds, then tail and first finalization multiply
            ST_HBLK: begin
               if (blk_ff != nblk) begin
                  h_ff   <= round_h;
                  blk_ff <= blk_ff + 2'd1;
               end else begin
                  state_ff <= ST_FIN2;
               end
            end
            ST_FIN2: begin
               state_ff <= ST_IDX;
            end
            ST_IDX: begin
               state_ff <= ST_RD;
            end
            ST_RD: begin
               idx_ff   <= prod_idx;
               state_ff <= ST_CHK;
            end
            // test the bit, set it on add
            ST_CHK: begin
               if (!mem_rdata) begin
                  present_ff <= 1'b0;
               end
               if ((!mem_rdata && (cmd_ff == CMD_TEST)) || last_seed) begin
                  state_ff <= ST_DONE;
               end else begin
                  seed_ff  <= seed_ff + SW'(1);
                  state_ff <= ST_SEED;
               end
            end
            // hand the result to the output register
            ST_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_present_ff <= present_ff;
                  state_ff       <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== src/bfm_checker.sv =====
// ----------------------------------------------------------------------------
// bfm_checker
// Port-level checks of the bloom filter, bound to the top level.
// ----------------------------------------------------------------------------
module bfm_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_present
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_present))
      else $error("stalled result changed");

   // no result right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // block is busy after taking a transaction
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("accepted back to back");

   // a new result only comes out of a busy block
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without work in progress");

endmodule

bind bloom_filter_murmur3 bfm_checker u_bfm_checker (.*);
